// ----- hdl/psrf_pkg.sv -----
// Package for the printable string run finder.
// Constants, run record and queue entry types; no dependencies.
package psrf_pkg;

   localparam logic [7:0]  PRINT_LO        = 8'h20;
   localparam logic [7:0]  PRINT_HI        = 8'h7F;
   localparam logic [15:0] MIN_CHARS_RESET = 16'd4;
   localparam int          QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [31:0] run_start;
      logic [31:0] run_bytes;
      logic        wide;
   } run_rec_type;

   // up to two runs closed by one byte, already in order of run end
   typedef struct packed {
      logic        two_runs;
      run_rec_type rec0;
      run_rec_type rec1;
   } run_pair_type;

endpackage

// ----- hdl/psrf_if.sv -----
// Channel interfaces for the printable string run finder: input bytes,
// result beats and the min_chars write port. Depends on nothing.
interface psrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;
   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface psrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] run_start;
   logic [31:0] run_bytes;
   logic        wide;
   logic        last_of_item;
   modport source (output valid, output run_start, output run_bytes, output wide,
                   output last_of_item, input ready);
   modport sink   (input valid, input run_start, input run_bytes, input wide,
                   input last_of_item, output ready);
endinterface

interface psrf_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] min_chars;
   modport source (output valid, output min_chars, input ready);
   modport sink   (input valid, input min_chars, output ready);
endinterface

// ----- hdl/psrf_front.sv -----
// Front end: takes bytes, tracks ASCII and UTF-16LE runs, qualifies closed
// runs against min_chars and orders them. Uses psrf_pkg and psrf_if.
module psrf_front
   import psrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   psrf_req_if.sink     req_ch,
   psrf_csr_if.sink     csr_ch,
   input  logic         queue_full,
   output logic         push,
   output run_pair_type push_data
);

   typedef struct packed {
      logic        ok;
      logic [31:0] len;
   } qual_type;

   logic [15:0] min_chars_ff,  min_chars_in;
   logic [31:0] offset_ff,     offset_in;
   logic        phase_ff,      phase_in;
   logic        a_active_ff,   a_active_in;
   logic [31:0] a_start_ff,    a_start_in;
   logic        w_active_ff,   w_active_in;
   logic [31:0] w_start_ff,    w_start_in;
   logic [7:0]  held_ff,       held_in;

   logic        accept;
   logic        a_print, pair_ok;
   logic [31:0] pair_at;
   logic [32:0] pos_next;
   logic        a_cand, w_cand;
   logic [31:0] a_cs, w_cs;
   logic [32:0] a_ce, w_ce;
   logic        w_act_after;
   logic [31:0] w_start_after;
   qual_type    a_q, w_q;
   logic        swap;
   run_rec_type a_rec, w_rec;

   function automatic logic printable(input logic [7:0] b);
      printable = (b >= PRINT_LO) && (b < PRINT_HI);
   endfunction

   function automatic qual_type qualify(input logic [31:0] s, input logic [32:0] e,
                                        input logic [16:0] need);
      logic [32:0] diff;
      logic        gt;
      qual_type    q;
      gt    = e > {1'b0, s};
      diff  = gt ? (e - {1'b0, s}) : 33'd0;
      q.ok  = gt && (diff >= {16'd0, need});
      q.len = diff[32] ? 32'hFFFF_FFFF : diff[31:0];
      qualify = q;
   endfunction

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = !queue_full;
   assign csr_ch.ready  = 1'b1;

   always_comb begin
      a_print   = printable(req_ch.data_byte);
      pair_ok   = (req_ch.data_byte == 8'd0) && printable(held_ff);
      pair_at   = (offset_ff != 32'd0) ? offset_ff - 32'd1 : 32'd0;
      pos_next  = {1'b0, offset_ff} + 33'd1;

      // ASCII tracker
      a_cand = 1'b0;
      a_cs   = a_start_ff;
      a_ce   = {1'b0, offset_ff};
      if (!a_print && a_active_ff) begin
         a_cand = 1'b1;
      end else if (req_ch.end_of_data && a_print) begin
         a_cand = 1'b1;
         a_cs   = a_active_ff ? a_start_ff : offset_ff;
         a_ce   = pos_next;
      end

      // wide tracker, pair completes on the odd byte
      w_cand        = 1'b0;
      w_cs          = w_start_ff;
      w_ce          = {1'b0, pair_at};
      w_act_after   = w_active_ff;
      w_start_after = w_start_ff;
      if (phase_ff) begin
         if (pair_ok) begin
            w_act_after   = 1'b1;
            w_start_after = w_active_ff ? w_start_ff : pair_at;
         end else begin
            w_act_after = 1'b0;
            w_cand      = w_active_ff;
         end
      end
      if (req_ch.end_of_data && w_act_after) begin
         w_cand = 1'b1;
         w_cs   = w_start_after;
         w_ce   = phase_ff ? pos_next : {1'b0, offset_ff};
      end

      a_q = qualify(a_cs, a_ce, {1'b0, min_chars_ff});
      w_q = qualify(w_cs, w_ce, {min_chars_ff, 1'b0});

      a_rec = '{run_start: a_cs, run_bytes: a_q.len, wide: 1'b0};
      w_rec = '{run_start: w_cs, run_bytes: w_q.len, wide: 1'b1};

      swap = (a_cand && a_q.ok) && (w_cand && w_q.ok) && (w_ce < a_ce);
      push = accept && ((a_cand && a_q.ok) || (w_cand && w_q.ok));
      push_data.two_runs = (a_cand && a_q.ok) && (w_cand && w_q.ok);
      if (!(a_cand && a_q.ok) || swap) begin
         push_data.rec0 = w_rec;
         push_data.rec1 = a_rec;
      end else begin
         push_data.rec0 = a_rec;
         push_data.rec1 = w_rec;
      end
   end

   always_comb begin
      min_chars_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.min_chars : min_chars_ff;
      offset_in    = offset_ff;
      phase_in     = phase_ff;
      a_active_in  = a_active_ff;
      a_start_in   = a_start_ff;
      w_active_in  = w_active_ff;
      w_start_in   = w_start_ff;
      held_in      = held_ff;
      if (accept) begin
         if (req_ch.end_of_data) begin
            offset_in   = 32'd0;
            phase_in    = 1'b0;
            a_active_in = 1'b0;
            a_start_in  = 32'd0;
            w_active_in = 1'b0;
            w_start_in  = 32'd0;
            held_in     = 8'd0;
         end else begin
            offset_in   = (offset_ff != 32'hFFFF_FFFF) ? pos_next[31:0] : offset_ff;
            phase_in    = !phase_ff;
            a_active_in = a_print;
            a_start_in  = (a_print && !a_active_ff) ? offset_ff : a_start_ff;
            w_active_in = w_act_after;
            w_start_in  = w_start_after;
            held_in     = phase_ff ? held_ff : req_ch.data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_chars_ff <= MIN_CHARS_RESET;
         offset_ff    <= 32'd0;
         phase_ff     <= 1'b0;
         a_active_ff  <= 1'b0;
         a_start_ff   <= 32'd0;
         w_active_ff  <= 1'b0;
         w_start_ff   <= 32'd0;
         held_ff      <= 8'd0;
      end else begin
         min_chars_ff <= min_chars_in;
         offset_ff    <= offset_in;
         phase_ff     <= phase_in;
         a_active_ff  <= a_active_in;
         a_start_ff   <= a_start_in;
         w_active_ff  <= w_active_in;
         w_start_ff   <= w_start_in;
         held_ff      <= held_in;
      end
   end

endmodule

// ----- hdl/psrf_queue.sv -----
// Short FIFO of qualified run pairs between front and back end.
// Uses psrf_pkg.
module psrf_queue
   import psrf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  run_pair_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output run_pair_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   run_pair_type           mem [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff,  count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/psrf_back.sv -----
// Back end: unpacks queued run pairs into result beats through an output
// register. Uses psrf_pkg and psrf_if.
module psrf_back
   import psrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         not_empty,
   input  run_pair_type head,
   output logic         pop,
   psrf_rsp_if.source   rsp_ch
);

   logic        out_valid_ff, out_valid_in;
   run_rec_type out_rec_ff,   out_rec_in;
   logic        out_last_ff,  out_last_in;
   logic        sel_ff,       sel_in;
   logic        load;
   logic        last_here;

   always_comb begin
      load         = not_empty && (!out_valid_ff || rsp_ch.ready);
      last_here    = !head.two_runs || sel_ff;
      pop          = load && last_here;
      out_valid_in = load || (out_valid_ff && !rsp_ch.ready);
      out_rec_in   = out_rec_ff;
      out_last_in  = out_last_ff;
      sel_in       = sel_ff;
      if (load) begin
         out_rec_in  = sel_ff ? head.rec1 : head.rec0;
         out_last_in = last_here;
         sel_in      = !last_here;
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff  <= out_rec_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sel_ff       <= sel_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.run_start    = out_rec_ff.run_start;
   assign rsp_ch.run_bytes    = out_rec_ff.run_bytes;
   assign rsp_ch.wide         = out_rec_ff.wide;
   assign rsp_ch.last_of_item = out_last_ff;

endmodule

// ----- hdl/printable_string_run_finder_core.sv -----
// Printable string run finder, top level. Uses psrf_pkg, psrf_if and the
// psrf_front, psrf_queue and psrf_back modules.
// Throughput: one byte per cycle; a byte closing two runs gives two result beats.
// A closed run passes through the run queue and then the output register to the result beat.
// Input stalls only when the run queue (QUEUE_DEPTH entries) is full.
// Synchronous reset clears trackers, offset, queue and output; min_chars returns to 4.
module printable_string_run_finder_core
   import psrf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   psrf_req_if.sink   req_ch,
   psrf_csr_if.sink   csr_ch,
   psrf_rsp_if.source rsp_ch
);

   logic         push, pop, full, not_empty;
   run_pair_type push_data, head;

   psrf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .queue_full(full),
      .push      (push),
      .push_data (push_data)
   );

   psrf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .full     (full),
      .not_empty(not_empty),
      .head     (head)
   );

   psrf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .not_empty(not_empty),
      .head     (head),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- tb/printable_string_run_finder_core_test.sv -----
// Testbench for printable_string_run_finder_core: drives byte beats, min_chars
// writes and a stalling result sink; a scoreboard class predicts every run.
// Depends on psrf_pkg, psrf_if and the core RTL.
module printable_string_run_finder_core_test;
   import psrf_pkg::*;

   localparam logic            KIND_ASCII    = 1'b0;
   localparam logic            KIND_WIDE     = 1'b1;
   localparam int              CYCLE_LIMIT   = 2_000_000;
   localparam int              SETTLE_CYCLES = 8;
   localparam int              PHASE_ITEMS   = 265;
   localparam longint unsigned SAT32         = 64'h0000_0000_FFFF_FFFF;

   typedef struct {
      run_rec_type     rec;
      longint unsigned run_end;
   } closed_run_type;

   typedef struct {
      run_rec_type rec;
      logic        last;
   } run_beat_type;

   class run_scoreboard;
      logic [15:0]     min_chars;
      longint unsigned byte_offset;
      bit              ascii_open;
      longint unsigned ascii_start;
      bit              wide_open;
      longint unsigned wide_start;
      logic [7:0]      held_byte;
      bit              odd_phase;
      closed_run_type  closed[$];
      run_beat_type    pending_beats[$];
      int              errors;

      function new();
         min_chars   = MIN_CHARS_RESET;
         byte_offset = 0;
         ascii_open  = 0;
         ascii_start = 0;
         wide_open   = 0;
         wide_start  = 0;
         held_byte   = 8'h00;
         odd_phase   = 0;
         errors      = 0;
      endfunction

      function void set_min_chars(logic [15:0] v);
         min_chars = v;
      endfunction

      function int pending();
         return pending_beats.size();
      endfunction

      function bit is_printable(logic [7:0] v);
         return v >= PRINT_LO && v < PRINT_HI;
      endfunction

      function void close_run(longint unsigned s, longint unsigned e,
                              longint unsigned need, logic kind);
         longint unsigned len;
         closed_run_type  c;
         len = (e > s) ? e - s : 0;
         if (len >= need && len > 0) begin
            c.rec.run_start = s[31:0];
            c.rec.run_bytes = (len > SAT32) ? 32'hFFFF_FFFF : len[31:0];
            c.rec.wide      = kind;
            c.run_end       = e;
            closed.push_back(c);
         end
      endfunction

      function void note_byte(logic [7:0] b, logic eod);
         longint unsigned pos;
         longint unsigned need_a;
         longint unsigned need_w;
         longint unsigned pair_at;
         closed_run_type  tmp;
         run_beat_type    beat;
         pos    = byte_offset;
         need_a = 64'(min_chars);
         need_w = need_a * 2;
         closed.delete();

         if (is_printable(b)) begin
            if (!ascii_open) begin
               ascii_open  = 1;
               ascii_start = pos;
            end
         end else begin
            if (ascii_open) close_run(ascii_start, pos, need_a, KIND_ASCII);
            ascii_open = 0;
         end

         // pair completes on the odd byte
         if (odd_phase) begin
            pair_at = (pos > 0) ? pos - 1 : 0;
            if (b == 8'h00 && is_printable(held_byte)) begin
               if (!wide_open) begin
                  wide_open  = 1;
                  wide_start = pair_at;
               end
            end else begin
               if (wide_open) close_run(wide_start, pair_at, need_w, KIND_WIDE);
               wide_open = 0;
            end
         end else begin
            held_byte = b;
         end

         if (eod) begin
            if (ascii_open) close_run(ascii_start, pos + 1, need_a, KIND_ASCII);
            if (wide_open) close_run(wide_start, odd_phase ? pos + 1 : pos, need_w, KIND_WIDE);
            byte_offset = 0;
            ascii_open  = 0;
            ascii_start = 0;
            wide_open   = 0;
            wide_start  = 0;
            held_byte   = 8'h00;
            odd_phase   = 0;
         end else begin
            byte_offset = (pos < SAT32) ? pos + 1 : SAT32;
            odd_phase   = !odd_phase;
         end

         if (closed.size() == 2 && closed[1].run_end < closed[0].run_end) begin
            tmp       = closed[0];
            closed[0] = closed[1];
            closed[1] = tmp;
         end
         foreach (closed[k]) begin
            beat.rec  = closed[k].rec;
            beat.last = (k == closed.size() - 1);
            pending_beats.push_back(beat);
         end
      endfunction

      task report(string field, longint unsigned got, longint unsigned want);
         errors++;
         $display("mismatch at %0t on %s: got 0x%0h, expected 0x%0h",
                  $time, field, got, want);
      endtask

      task check_beat(logic [31:0] start, logic [31:0] nbytes, logic kind, logic last);
         run_beat_type want;
         if (pending_beats.size() == 0) begin
            report("unexpected beat run_start", 64'(start), 0);
            return;
         end
         want = pending_beats.pop_front();
         if (start !== want.rec.run_start) report("run_start", start, want.rec.run_start);
         if (nbytes !== want.rec.run_bytes) report("run_bytes", nbytes, want.rec.run_bytes);
         if (kind !== want.rec.wide) report("wide", kind, want.rec.wide);
         if (last !== want.last) report("last_of_item", last, want.last);
      endtask
   endclass

   logic          clock         = 1'b0;
   logic          reset;
   run_scoreboard sb;
   int            src_idle_pct  = 33;
   int            sink_idle_pct = 33;
   int            items_sent    = 0;
   int unsigned   image_pos     = 0;
   int            cycle_count;
   logic [15:0]   phase_min [6] = '{16'd2, 16'd0, 16'd1, 16'd3, 16'd6, 16'd4};

   psrf_req_if req_ch ();
   psrf_rsp_if rsp_ch ();
   psrf_csr_if csr_ch ();

   printable_string_run_finder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) sb.set_min_chars(csr_ch.min_chars);
         if (req_ch.valid && req_ch.ready) sb.note_byte(req_ch.data_byte, req_ch.end_of_data);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_beat(rsp_ch.run_start, rsp_ch.run_bytes, rsp_ch.wide,
                          rsp_ch.last_of_item);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eod);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.end_of_data <= eod;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      image_pos = eod ? 0 : image_pos + 1;
   endtask

   task automatic send_ascii_text(input int n);
      for (int k = 0; k < n; k++)
         send_byte(8'($urandom_range(PRINT_HI - 1, PRINT_LO)), 1'b0);
   endtask

   task automatic send_wide_text(input int n);
      if (image_pos[0]) send_byte(8'($urandom_range(255, 0)), 1'b0);
      for (int k = 0; k < n; k++) begin
         send_byte(8'($urandom_range(PRINT_HI - 1, PRINT_LO)), 1'b0);
         send_byte(8'h00, 1'b0);
      end
   endtask

   task automatic write_min_chars(input logic [15:0] v);
      csr_ch.valid     <= 1'b1;
      csr_ch.min_chars <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int n_items);
      int first;
      int kind;
      int len;
      first = items_sent;
      while (items_sent - first < n_items) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            send_ascii_text($urandom_range(12, 1));
         end else if (kind < 72) begin
            send_wide_text($urandom_range(10, 1));
         end else if (kind < 87) begin
            len = $urandom_range(4, 1);
            for (int k = 0; k < len; k++) send_byte(8'($urandom_range(255, 0)), 1'b0);
         end else if (kind < 95) begin
            // wide text broken by a pair with a nonzero high byte
            send_wide_text($urandom_range(6, 1));
            send_byte(8'($urandom_range(PRINT_HI - 1, PRINT_LO)), 1'b0);
            send_byte(8'($urandom_range(255, 1)), 1'b0);
         end else begin
            send_byte(8'($urandom_range(255, 0)), 1'b1);
         end
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      sb                 = new();
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = 8'h00;
      req_ch.end_of_data = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.min_chars   = 16'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset min_chars: edge printables, closing on 0x80, wide run flushed at odd end
      send_byte(8'h20, 1'b0); send_byte(8'h7E, 1'b0); send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h61, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h62, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'h63, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h64, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h45, 1'b1);
      // ASCII run flushed at end of data
      send_byte(8'h7F, 1'b0); send_byte(8'h3A, 1'b0); send_byte(8'h3B, 1'b0);
      send_byte(8'h3C, 1'b0); send_byte(8'h3D, 1'b1);
      drain_and_settle();

      // one byte closes both runs; wide ends first
      write_min_chars(16'd1);
      send_byte(8'h41, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h42, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'h43, 1'b0); send_byte(8'h1F, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain_and_settle();

      for (int i = 0; i < 6; i++) begin
         if (i == 3) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         write_min_chars(phase_min[i]);
         run_random_phase(PHASE_ITEMS);
         drain_and_settle();
         src_idle_pct  = 33;
         sink_idle_pct = 33;
      end

      // largest min_chars: no run reaches the threshold
      write_min_chars(16'hFFFF);
      run_random_phase(40);
      send_byte(8'h00, 1'b1);
      drain_and_settle();

      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- printable_string_run_finder_core.f -----
hdl/psrf_pkg.sv
hdl/psrf_if.sv
hdl/psrf_front.sv
hdl/psrf_queue.sv
hdl/psrf_back.sv
hdl/printable_string_run_finder_core.sv
tb/printable_string_run_finder_core_test.sv
